[hdl/pmst_pkg.sv]
// Package for the Prim spanning tree block: sizes, command codes and the
// structures passed between the controller and the row of vertex cells.
// Depends on nothing.
`default_nettype none
package pmst_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int KEY_W        = WEIGHT_BITS + 1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [KEY_W-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  typedef struct packed {
    logic                   init;
    logic                   pick_en;
    logic                   update;
    logic [IDX_W-1:0]       pick;
    logic                   wr_en;
    logic                   clr_en;
    logic [IDX_W-1:0]       row_s;
    logic [IDX_W-1:0]       row_d;
    logic [WEIGHT_BITS-1:0] weight;
    logic [CNT_W-1:0]       n;
    logic                   load;
    logic                   shift;
  } ctrl_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic                   reached;
    logic [IDX_W-1:0]       parent;
    logic [WEIGHT_BITS-1:0] weight;
  } res_t;

endpackage
`default_nettype wire

[hdl/pmst_if.sv]
// Channel interfaces of the Prim spanning tree block: commands, results and
// the configuration write. Depends on pmst_pkg.
`default_nettype none
interface pmst_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          cmd;
  logic [5:0]                          source_vertex;
  logic [5:0]                          dest_vertex;
  logic [pmst_pkg::WEIGHT_BITS-1:0]    edge_weight;
  modport source (output valid, cmd, source_vertex, dest_vertex, edge_weight, input ready);
  modport sink   (input valid, cmd, source_vertex, dest_vertex, edge_weight, output ready);
endinterface

interface pmst_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [5:0]                          parent_vertex;
  logic [5:0]                          child_vertex;
  logic [pmst_pkg::WEIGHT_BITS-1:0]    tree_weight;
  logic                                reached;
  logic                                last;
  modport source (output valid, parent_vertex, child_vertex, tree_weight, reached, last,
                  input ready);
  modport sink   (input valid, parent_vertex, child_vertex, tree_weight, reached, last,
                  output ready);
endinterface

interface pmst_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

[hdl/pmst_cell.sv]
// One vertex cell: holds one column of the weight matrix, the vertex key,
// parent and tree flag, and passes the minimum token and results along.
// Depends on pmst_pkg.
`default_nettype none
module pmst_cell (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [pmst_pkg::IDX_W-1:0]     cell_idx,
  input  pmst_pkg::ctrl_t               ctrl,
  input  pmst_pkg::tok_t                tok_in,
  output pmst_pkg::tok_t                tok_out,
  input  pmst_pkg::res_t                res_in,
  output pmst_pkg::res_t                res_out
);
  logic [pmst_pkg::WEIGHT_BITS-1:0] mem [pmst_pkg::MAX_VERTICES];
  logic [pmst_pkg::WEIGHT_BITS-1:0] rd;
  logic [pmst_pkg::KEY_W-1:0]       key;
  logic [pmst_pkg::IDX_W-1:0]       parent;
  logic                             in_tree;
  pmst_pkg::tok_t                   tok;
  pmst_pkg::res_t                   res;

  logic                             active;
  logic                             wr;
  logic [pmst_pkg::IDX_W-1:0]       wr_addr;
  logic [pmst_pkg::WEIGHT_BITS-1:0] wr_data;
  logic                             reached;

  assign active  = {1'b0, cell_idx} < ctrl.n;
  assign wr      = ctrl.clr_en
                   || (ctrl.wr_en && (cell_idx == ctrl.row_d || cell_idx == ctrl.row_s));
  assign wr_addr = ctrl.clr_en ? ctrl.row_s
                   : ((cell_idx == ctrl.row_d) ? ctrl.row_s : ctrl.row_d);
  assign wr_data = ctrl.clr_en ? '0 : ctrl.weight;
  assign reached = !key[pmst_pkg::WEIGHT_BITS];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.pick_en) begin
      rd <= mem[ctrl.pick];
    end
  end

  always_ff @(posedge clk) begin
    if (active && !in_tree && key < tok_in.key) begin
      tok <= '{key: key, idx: cell_idx};
    end else begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tree <= 1'b0;
    end else if (ctrl.init) begin
      in_tree <= 1'b0;
    end else if (ctrl.pick_en && ctrl.pick == cell_idx) begin
      in_tree <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      key    <= (cell_idx == '0) ? '0 : pmst_pkg::KEY_INF;
      parent <= '0;
    end else if (ctrl.update && rd != '0 && !in_tree && {1'b0, rd} < key) begin
      key    <= {1'b0, rd};
      parent <= ctrl.pick;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      res.reached <= reached;
      res.parent  <= reached ? parent : '0;
      res.weight  <= reached ? key[pmst_pkg::WEIGHT_BITS-1:0] : '0;
    end else if (ctrl.shift) begin
      res <= res_in;
    end
  end

  assign tok_out = tok;
  assign res_out = res;
endmodule
`default_nettype wire

[hdl/prim_minimum_spanning_tree.sv]
// Top level: controller and the row of vertex cells. A clear, and the pass
// after reset, zero the weight matrix row by row. A run repeats a minimum
// search, rippling through the cell row, and a key update per tree vertex
// added, plus one final search, then gives one result per cycle while the
// result consumer is ready. Reset clears the matrix, taking no commands.
// Depends on pmst_pkg, pmst_if and pmst_cell.
`default_nettype none
module prim_minimum_spanning_tree (
  input  wire           clk,
  input  wire           rst,
  pmst_req_if.sink      req,
  pmst_rsp_if.source    rsp,
  pmst_cfg_if.sink      cfg
);
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  localparam int N = pmst_pkg::MAX_VERTICES;

  state_t                        state, state_next;
  logic [6:0]                    vcount;
  logic [pmst_pkg::CNT_W-1:0]    n;
  logic [pmst_pkg::IDX_W-1:0]    row_cnt;
  logic [pmst_pkg::CNT_W-1:0]    sc;
  logic [pmst_pkg::CNT_W-1:0]    step_cnt;
  logic [pmst_pkg::CNT_W-1:0]    emit_cnt;
  logic [pmst_pkg::IDX_W-1:0]    pick_reg;
  logic                          o_valid;
  pmst_pkg::res_t                o_res;
  logic [pmst_pkg::IDX_W-1:0]    o_child;
  logic                          o_last;

  pmst_pkg::ctrl_t               ctrl;
  pmst_pkg::tok_t                tok  [N+1];
  pmst_pkg::res_t                res  [N+1];
  logic                          accept;
  logic                          search_end;
  logic                          run_done;
  logic                          out_free;

  assign n = (vcount < 7'd2) ? pmst_pkg::CNT_W'(2)
             : ((vcount > 7'(N)) ? pmst_pkg::CNT_W'(N) : pmst_pkg::CNT_W'(vcount));

  assign cfg.ready  = 1'b1;
  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign search_end = (state == S_SEARCH) && (sc == pmst_pkg::CNT_W'(N));
  assign run_done   = tok[N].key[pmst_pkg::WEIGHT_BITS] || (step_cnt == n - 1'b1);
  assign out_free   = !o_valid || rsp.ready;

  always_comb begin
    ctrl         = '0;
    ctrl.n       = n;
    ctrl.row_s   = (state == S_CLEAR) ? row_cnt : req.source_vertex;
    ctrl.row_d   = req.dest_vertex;
    ctrl.weight  = req.edge_weight;
    ctrl.clr_en  = (state == S_CLEAR);
    ctrl.wr_en   = accept && req.cmd == pmst_pkg::CMD_WRITE
                   && {1'b0, req.source_vertex} < 7'(N)
                   && {1'b0, req.dest_vertex} < 7'(N);
    ctrl.init    = accept && req.cmd == pmst_pkg::CMD_RUN;
    ctrl.pick    = (state == S_UPDATE) ? pick_reg : tok[N].idx;
    ctrl.pick_en = search_end && !run_done;
    ctrl.update  = (state == S_UPDATE);
    ctrl.load    = search_end && run_done;
    ctrl.shift   = (state == S_EMIT) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (row_cnt == pmst_pkg::IDX_W'(N - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            pmst_pkg::CMD_RUN:   state_next = S_SEARCH;
            pmst_pkg::CMD_CLEAR: state_next = S_CLEAR;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (search_end) state_next = run_done ? S_EMIT : S_UPDATE;
      end
      S_UPDATE: state_next = S_SEARCH;
      S_EMIT: begin
        if (out_free && emit_cnt == n - 2'd2) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      vcount <= 7'd64;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) vcount <= cfg.vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      sc       <= '0;
      step_cnt <= '0;
      emit_cnt <= '0;
    end else begin
      if (state == S_CLEAR) row_cnt <= row_cnt + 1'b1;
      else row_cnt <= '0;
      if (state == S_SEARCH) sc <= sc + 1'b1;
      else sc <= '0;
      if (ctrl.init) step_cnt <= '0;
      else if (ctrl.pick_en) step_cnt <= step_cnt + 1'b1;
      if (ctrl.load) emit_cnt <= '0;
      else if (ctrl.shift) emit_cnt <= emit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pick_en) pick_reg <= tok[N].idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ctrl.shift) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      o_res   <= res[1];
      o_child <= pmst_pkg::IDX_W'(emit_cnt + 1'b1);
      o_last  <= (emit_cnt == n - 2'd2);
    end
  end

  assign rsp.valid         = o_valid;
  assign rsp.parent_vertex = o_res.parent;
  assign rsp.child_vertex  = o_child;
  assign rsp.tree_weight   = o_res.weight;
  assign rsp.reached       = o_res.reached;
  assign rsp.last          = o_last;

  assign tok[0] = '{key: pmst_pkg::KEY_INF, idx: '0};
  assign res[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    pmst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (pmst_pkg::IDX_W'(i)),
      .ctrl     (ctrl),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .res_in   (res[i+1]),
      .res_out  (res[i])
    );
  end
endmodule
`default_nettype wire

[hdl/pmst_checker.sv]
// Port-level checks for the Prim spanning tree block, bound to the top level.
// Depends on pmst_pkg and prim_minimum_spanning_tree.
`default_nettype none
module pmst_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                req_ready,
  input wire                                rsp_valid,
  input wire                                rsp_ready,
  input wire [5:0]                          rsp_parent,
  input wire [5:0]                          rsp_child,
  input wire [pmst_pkg::WEIGHT_BITS-1:0]    rsp_weight,
  input wire                                rsp_reached,
  input wire                                rsp_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_child))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_last |=> !rsp_valid || rsp_child == $past(rsp_child) + 6'd1)
    else $error("results out of vertex order");

  a_unreached: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_reached |-> rsp_parent == 6'd0 && rsp_weight == '0)
    else $error("unreached vertex carries a tree edge");

  a_child: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_child != 6'd0)
    else $error("result for vertex zero");

  a_clear: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("commands taken during the clearing pass");
endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_parent  (rsp.parent_vertex),
  .rsp_child   (rsp.child_vertex),
  .rsp_weight  (rsp.tree_weight),
  .rsp_reached (rsp.reached),
  .rsp_last    (rsp.last)
);
`default_nettype wire

[tb/tb_prim_minimum_spanning_tree.sv]
// Self-checking testbench for prim_minimum_spanning_tree: directed and random edge writes,
// clears and runs, results checked against a directed table or a spanning tree predictor.
// Depends on pmst_pkg, pmst_if and the block itself.
`default_nettype none
module tb_prim_minimum_spanning_tree;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    logic [5:0]  parent;
    logic [5:0]  child;
    logic [15:0] weight;
    logic        reached;
    logic        last;
  } tree_edge_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] weight;
    bit          typed;
    tree_edge_t  want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  pmst_req_if req ();
  pmst_rsp_if rsp ();
  pmst_cfg_if cfg ();

  prim_minimum_spanning_tree dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always #5 clk = ~clk;

  logic [15:0] adjacency [pmst_pkg::MAX_VERTICES][pmst_pkg::MAX_VERTICES];
  logic [6:0]  vertex_limit;
  tree_edge_t  tree_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          runs_sent = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          rx_hold = 0;

  function automatic void predict_tree();
    logic [pmst_pkg::KEY_W-1:0] key [pmst_pkg::MAX_VERTICES];
    logic [5:0]                 par [pmst_pkg::MAX_VERTICES];
    bit                         joined [pmst_pkg::MAX_VERTICES];
    logic [pmst_pkg::KEY_W-1:0] low;
    int                         n, pick;
    bit                         found;
    tree_edge_t                 r;
    n = (vertex_limit < 2) ? 2 : ((vertex_limit > pmst_pkg::MAX_VERTICES)
        ? pmst_pkg::MAX_VERTICES : int'(vertex_limit));
    for (int v = 0; v < pmst_pkg::MAX_VERTICES; v++) begin
      key[v] = pmst_pkg::KEY_INF;
      par[v] = '0;
      joined[v] = 1'b0;
    end
    key[0] = '0;
    for (int step = 0; step + 1 < n; step++) begin
      low = pmst_pkg::KEY_INF;
      pick = 0;
      found = 1'b0;
      for (int v = 0; v < n; v++) begin
        if (!joined[v] && key[v] < low) begin
          low = key[v];
          pick = v;
          found = 1'b1;
        end
      end
      if (!found) break;
      joined[pick] = 1'b1;
      for (int v = 0; v < n; v++) begin
        if (adjacency[pick][v] != 0 && !joined[v] && {1'b0, adjacency[pick][v]} < key[v]) begin
          par[v] = 6'(pick);
          key[v] = {1'b0, adjacency[pick][v]};
        end
      end
    end
    for (int v = 1; v < n; v++) begin
      r.reached = key[v] < pmst_pkg::KEY_INF;
      r.parent  = r.reached ? par[v] : 6'd0;
      r.child   = 6'(v);
      r.weight  = r.reached ? adjacency[v][par[v]] : 16'd0;
      r.last    = (v + 1 == n);
      tree_q.push_back(r);
    end
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic [5:0] s, logic [5:0] d,
                                        logic [15:0] w);
    case (cmd)
      pmst_pkg::CMD_WRITE: begin
        adjacency[s][d] = w;
        adjacency[d][s] = w;
      end
      pmst_pkg::CMD_CLEAR: begin
        foreach (adjacency[i, j]) adjacency[i][j] = '0;
      end
      pmst_pkg::CMD_RUN: begin
        predict_tree();
        runs_sent++;
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(logic [1:0] cmd, logic [5:0] s, logic [5:0] d, logic [15:0] w);
    while ($urandom_range(99) < tx_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.source_vertex <= s;
    req.dest_vertex <= d;
    req.edge_weight <= w;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  task automatic write_vertex_count(logic [6:0] value);
    req.valid <= 1'b0;
    while (tree_q.size() != 0) @(posedge clk);
    repeat (pmst_pkg::MAX_VERTICES + 16) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.vertex_count <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    vertex_limit = value;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("prim_minimum_spanning_tree verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    tree_edge_t got, want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.parent_vertex, rsp.child_vertex, rsp.tree_weight, rsp.reached, rsp.last};
        results_seen++;
        if (tree_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = tree_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  initial begin
    cmd_row_t    rows [$];
    logic [6:0]  phase_count [NUM_PHASES];
    int          span, pick;
    logic [1:0]  cmd;
    logic [5:0]  s, d;
    logic [15:0] w;

    phase_count = '{7'd8, 7'd127, 7'd0, 7'd5, 7'd64, 7'd8};
    req.valid = 1'b0;
    req.cmd = pmst_pkg::CMD_WRITE;
    req.source_vertex = '0;
    req.dest_vertex = '0;
    req.edge_weight = '0;
    cfg.valid = 1'b0;
    cfg.vertex_count = '0;
    rsp.ready = 1'b0;
    foreach (adjacency[i, j]) adjacency[i][j] = '0;
    vertex_limit = 7'd64;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      '{pmst_pkg::CMD_RUN,   6'd0,  6'd0,  16'h0000, 1, '{6'd0, 6'd1, 16'h0000, 1'b0, 1'b1}},
      '{pmst_pkg::CMD_WRITE, 6'd0,  6'd1,  16'hFFFF, 0, '0},
      '{pmst_pkg::CMD_RUN,   6'd0,  6'd0,  16'h0000, 1, '{6'd0, 6'd1, 16'hFFFF, 1'b1, 1'b1}},
      '{pmst_pkg::CMD_WRITE, 6'd1,  6'd0,  16'h0001, 0, '0},
      '{pmst_pkg::CMD_RUN,   6'd63, 6'd63, 16'hFFFF, 1, '{6'd0, 6'd1, 16'h0001, 1'b1, 1'b1}},
      '{pmst_pkg::CMD_WRITE, 6'd0,  6'd0,  16'h0005, 0, '0},
      '{pmst_pkg::CMD_RUN,   6'd0,  6'd0,  16'h0000, 1, '{6'd0, 6'd1, 16'h0001, 1'b1, 1'b1}},
      '{pmst_pkg::CMD_WRITE, 6'd0,  6'd1,  16'h0000, 0, '0},
      '{pmst_pkg::CMD_RUN,   6'd0,  6'd0,  16'h0000, 1, '{6'd0, 6'd1, 16'h0000, 1'b0, 1'b1}},
      '{pmst_pkg::CMD_WRITE, 6'd63, 6'd63, 16'hA5A5, 0, '0},
      '{pmst_pkg::CMD_WRITE, 6'd63, 6'd1,  16'h5A5A, 0, '0},
      '{pmst_pkg::CMD_WRITE, 6'd0,  6'd1,  16'h0007, 0, '0},
      '{CMD_SPARE,           6'd42, 6'd21, 16'hFFFF, 0, '0},
      '{pmst_pkg::CMD_RUN,   6'd0,  6'd0,  16'h0000, 1, '{6'd0, 6'd1, 16'h0007, 1'b1, 1'b1}},
      '{pmst_pkg::CMD_CLEAR, 6'd0,  6'd0,  16'h0000, 0, '0},
      '{pmst_pkg::CMD_RUN,   6'd0,  6'd0,  16'h0000, 1, '{6'd0, 6'd1, 16'h0000, 1'b0, 1'b1}}
    };

    write_vertex_count(7'd2);
    foreach (rows[i]) begin
      send_command(rows[i].cmd, rows[i].src, rows[i].dst, rows[i].weight);
      if (rows[i].typed) begin
        tree_q.push_back(rows[i].want);
        runs_sent++;
      end else begin
        apply_command(rows[i].cmd, rows[i].src, rows[i].dst, rows[i].weight);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_vertex_count(phase_count[ph]);
      tx_idle = (ph < 2) ? 36 : ((ph < 4) ? 56 : 0);
      rx_idle = (ph < 2) ? 56 : ((ph < 4) ? 36 : 0);
      span = (phase_count[ph] < 2) ? 2 : ((phase_count[ph] > 64) ? 64 : int'(phase_count[ph]));
      for (int k = 0; k < 36; k++) begin
        pick = $urandom_range(99);
        cmd = (pick < 78) ? pmst_pkg::CMD_WRITE : ((pick < 92) ? pmst_pkg::CMD_RUN :
              ((pick < 97) ? pmst_pkg::CMD_CLEAR : CMD_SPARE));
        if (ph == 0 && k == 6) begin
          rx_hold = 400;
          cmd = pmst_pkg::CMD_RUN;
        end
        if ($urandom_range(9) == 0) begin
          s = 6'($urandom);
          d = 6'($urandom);
        end else begin
          s = 6'($urandom_range(span - 1));
          d = 6'($urandom_range(span - 1));
        end
        case ($urandom_range(3))
          0: w = 16'($urandom);
          1: w = 16'(32'hFFFF - $urandom_range(2));
          default: w = 16'($urandom_range(4));
        endcase
        send_command(cmd, s, d, w);
        apply_command(cmd, s, d, w);
      end
    end
    req.valid <= 1'b0;

    while (tree_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d commands including %0d spanning tree runs; checked %0d tree edges.",
             items_sent, runs_sent, results_seen);
    $display("Vertex counts 2, 0, 5, 8, 64 and 127 were used under three idling patterns.");
    if (mismatches == 0 && tree_q.size() == 0) begin
      $display("prim_minimum_spanning_tree verification clean");
    end else begin
      $display("prim_minimum_spanning_tree verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/pmst_pkg.sv
hdl/pmst_if.sv
hdl/pmst_cell.sv
hdl/prim_minimum_spanning_tree.sv
hdl/pmst_checker.sv
tb/tb_prim_minimum_spanning_tree.sv
